/* rtl/fat_cluster_chain_engine_defines.svh */
// Assertion macros for the cluster chain engine checkers.
`ifndef FAT_CLUSTER_CHAIN_ENGINE_DEFINES_SVH
`define FAT_CLUSTER_CHAIN_ENGINE_DEFINES_SVH

// Generic clocked assertion with asynchronous active-low reset.
`define FCCE_ASSERT(label, ck, rst_n, prop, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Same, on the usual clock and reset names.
`define FCCE_CHECK(label, prop, msg) `FCCE_ASSERT(label, clk, arst_n, prop, msg)

`endif

/* rtl/fce_pkg.sv */
package fce_pkg;

	localparam int unsigned TABLE_DEPTH = 4096;

	localparam int unsigned LINK_W = 28;
	localparam int unsigned CLUS_W = 12;
	localparam int unsigned STEP_W = 12;
	localparam int unsigned CNT_W  = 13;
	localparam int unsigned CFG_W  = 12;
	localparam int unsigned LIM_W  = CFG_W + 1;
	localparam int unsigned LIM_MAX = (2 ** CFG_W) + 1;

	localparam logic [CFG_W-1:0]  TOTAL_RESET = 12'd4094;
	localparam logic [LINK_W-1:0] LINK_ALL    = 28'hFFF_FFFF;
	localparam logic [LINK_W-1:0] END_MARK    = 28'hFFF_FFF8;
	localparam logic [LINK_W-1:0] FREE_ENTRY  = 28'h000_0000;
	localparam logic [LINK_W-1:0] FIRST_DATA  = 28'd2;

	typedef enum logic [2:0] {
		REQ_READ  = 3'd0,
		REQ_WRITE = 3'd1,
		REQ_ALLOC = 3'd2,
		REQ_FREE  = 3'd3,
		REQ_WALK  = 3'd4,
		REQ_COUNT = 3'd5
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_END  = 2'd2,
		ST_BAD  = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [CLUS_W-1:0] cluster;
		logic [LINK_W-1:0] entry_value;
		logic [STEP_W-1:0] link_steps;
	} request_t;

	typedef struct packed {
		logic [LINK_W-1:0] result_cluster;
		logic [CNT_W-1:0]  chain_count;
		status_t           status;
	} result_t;

	function automatic logic is_end(input logic [LINK_W-1:0] v);
		return (v < FIRST_DATA) || (v >= END_MARK);
	endfunction

endpackage

/* rtl/fce_req_if.sv */
interface fce_req_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    req_type;
	logic [fce_pkg::CLUS_W-1:0]    cluster;
	logic [fce_pkg::LINK_W-1:0]    entry_value;
	logic [fce_pkg::STEP_W-1:0]    link_steps;

	modport source (output valid, req_type, cluster, entry_value, link_steps, input ready);
	modport sink   (input valid, req_type, cluster, entry_value, link_steps, output ready);
endinterface

/* rtl/fce_rsp_if.sv */
interface fce_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [fce_pkg::LINK_W-1:0]    result_cluster;
	logic [fce_pkg::CNT_W-1:0]     chain_count;
	logic [1:0]                    status;

	modport source (output valid, result_cluster, chain_count, status, input ready);
	modport sink   (input valid, result_cluster, chain_count, status, output ready);
endinterface

/* rtl/fce_cfg_if.sv */
interface fce_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [fce_pkg::CFG_W-1:0]     total_clusters;

	modport source (output valid, total_clusters, input ready);
	modport sink   (input valid, total_clusters, output ready);
endinterface

/* rtl/fce_ram.sv */
module fce_ram #(
	parameter int unsigned WIDTH = 28,
	parameter int unsigned DEPTH = 4096,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/fce_engine.sv */
module fce_engine #(
	parameter int unsigned DEPTH = fce_pkg::TABLE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [fce_pkg::CFG_W-1:0]  total,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  fce_pkg::request_t          req,
	output logic                       res_valid,
	input  logic                       res_ready,
	output fce_pkg::result_t           res
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned LW = fce_pkg::LINK_W;
	localparam int unsigned LIMW = fce_pkg::LIM_W;
	localparam logic [LIMW-1:0] LIM_CAP = (DEPTH > fce_pkg::LIM_MAX) ?
		LIMW'(fce_pkg::LIM_MAX) : LIMW'(DEPTH);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_READ, S_ALLOC, S_FREE, S_WALK, S_COUNT, S_DONE
	} state_t;

	state_t                     state_q;
	logic [AW-1:0]              clr_q;
	logic [LW-1:0]              cur_q;
	logic [fce_pkg::CNT_W-1:0]  cnt_q;
	logic [fce_pkg::STEP_W-1:0] idx_q;
	logic [fce_pkg::STEP_W-1:0] step_q;
	logic                       first_q;
	logic                       pend_q;
	logic                       fwd_q;
	logic [LW-1:0]              fwd_data_q;
	logic [LW-1:0]              res_q;
	fce_pkg::status_t           st_q;

	logic [LIMW-1:0] lim_sum, lim, nmax;
	logic [LW-1:0]   lim_l, rd_data, eff_rd, x, cur_m1, clus_l;
	logic            x_end, x_bad, in_tab, accept;
	logic            rd_en, wr_en;
	logic [AW-1:0]   rd_addr, wr_addr;
	logic [LW-1:0]   wr_data;
	logic            fin, adv, cnt_inc, idx_inc;
	logic [LW-1:0]   fin_res;
	fce_pkg::status_t fin_st;

	assign lim_sum = LIMW'(total) + LIMW'(fce_pkg::FIRST_DATA);
	assign lim     = (lim_sum > LIM_CAP) ? LIM_CAP : lim_sum;
	assign nmax    = lim - LIMW'(fce_pkg::FIRST_DATA);
	assign lim_l   = LW'(lim);

	assign eff_rd = fwd_q ? fwd_data_q : rd_data;
	assign x      = first_q ? cur_q : eff_rd;
	assign x_end  = fce_pkg::is_end(x);
	assign x_bad  = x >= lim_l;
	assign cur_m1 = cur_q - LW'(1);
	assign clus_l = LW'(req.cluster);
	assign in_tab = 32'(req.cluster) < 32'(DEPTH);
	assign accept = req_valid && req_ready;

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res.result_cluster = res_q;
	assign res.chain_count    = cnt_q;
	assign res.status         = st_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = x[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = cur_q[AW-1:0];
		wr_data = fce_pkg::FREE_ENTRY;
		fin     = 1'b0;
		fin_res = '0;
		fin_st  = fce_pkg::ST_OK;
		adv     = 1'b0;
		cnt_inc = 1'b0;
		idx_inc = 1'b0;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			S_IDLE: begin
				if (accept && in_tab) begin
					if (req.req_type == fce_pkg::REQ_READ) begin
						rd_en   = 1'b1;
						rd_addr = clus_l[AW-1:0];
					end
					if (req.req_type == fce_pkg::REQ_WRITE) begin
						wr_en   = 1'b1;
						wr_addr = clus_l[AW-1:0];
						wr_data = req.entry_value;
					end
				end
			end
			S_ALLOC: begin
				if (pend_q && eff_rd == fce_pkg::FREE_ENTRY) begin
					wr_en   = 1'b1;
					wr_addr = cur_m1[AW-1:0];
					wr_data = fce_pkg::LINK_ALL;
					fin     = 1'b1;
					fin_res = cur_m1;
				end else if (cur_q < lim_l) begin
					rd_en   = 1'b1;
					rd_addr = cur_q[AW-1:0];
					adv     = 1'b1;
				end else begin
					fin    = 1'b1;
					fin_st = fce_pkg::ST_FULL;
				end
			end
			S_FREE: begin
				if (!first_q && eff_rd == fce_pkg::FREE_ENTRY) begin
					fin    = 1'b1;
					fin_st = fce_pkg::ST_BAD;
				end else begin
					if (!first_q) begin
						wr_en   = 1'b1;
						cnt_inc = 1'b1;
					end
					if (x_end) begin
						fin = 1'b1;
					end else if (x_bad) begin
						fin    = 1'b1;
						fin_st = fce_pkg::ST_BAD;
					end else begin
						rd_en = 1'b1;
						adv   = 1'b1;
					end
				end
			end
			S_WALK: begin
				if (idx_q == step_q) begin
					fin = 1'b1;
					if (x_end) begin
						fin_st = fce_pkg::ST_END;
					end else if (x_bad) begin
						fin_st = fce_pkg::ST_BAD;
					end else begin
						fin_res = x;
					end
				end else if (x_end) begin
					fin    = 1'b1;
					fin_st = fce_pkg::ST_END;
				end else if (x_bad || LIMW'(idx_q) >= nmax) begin
					fin    = 1'b1;
					fin_st = fce_pkg::ST_BAD;
				end else begin
					rd_en   = 1'b1;
					adv     = 1'b1;
					idx_inc = 1'b1;
				end
			end
			S_COUNT: begin
				if (x_end) begin
					fin = 1'b1;
				end else if (x_bad || cnt_q >= nmax) begin
					fin    = 1'b1;
					fin_st = fce_pkg::ST_BAD;
				end else begin
					rd_en   = 1'b1;
					adv     = 1'b1;
					cnt_inc = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			cur_q      <= '0;
			cnt_q      <= '0;
			idx_q      <= '0;
			step_q     <= '0;
			first_q    <= 1'b0;
			pend_q     <= 1'b0;
			fwd_q      <= 1'b0;
			fwd_data_q <= '0;
			res_q      <= '0;
			st_q       <= fce_pkg::ST_OK;
		end else begin
			// same-cycle read of an entry being written sees the new value
			fwd_q      <= rd_en && wr_en && (rd_addr == wr_addr);
			fwd_data_q <= wr_data;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cur_q   <= clus_l;
						cnt_q   <= '0;
						idx_q   <= '0;
						step_q  <= req.link_steps;
						first_q <= 1'b1;
						pend_q  <= 1'b0;
						res_q   <= '0;
						st_q    <= fce_pkg::ST_OK;
						unique case (req.req_type)
							fce_pkg::REQ_READ: begin
								if (in_tab) begin
									state_q <= S_READ;
								end else begin
									st_q    <= fce_pkg::ST_BAD;
									state_q <= S_DONE;
								end
							end
							fce_pkg::REQ_WRITE: begin
								if (!in_tab) begin
									st_q <= fce_pkg::ST_BAD;
								end
								state_q <= S_DONE;
							end
							fce_pkg::REQ_ALLOC: begin
								cur_q   <= fce_pkg::FIRST_DATA;
								state_q <= S_ALLOC;
							end
							fce_pkg::REQ_FREE:  state_q <= S_FREE;
							fce_pkg::REQ_WALK:  state_q <= S_WALK;
							fce_pkg::REQ_COUNT: state_q <= S_COUNT;
							default: begin
								st_q    <= fce_pkg::ST_BAD;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_READ: begin
					res_q   <= eff_rd;
					state_q <= S_DONE;
				end
				S_ALLOC, S_FREE, S_WALK, S_COUNT: begin
					if (cnt_inc) begin
						cnt_q <= cnt_q + fce_pkg::CNT_W'(1);
					end
					if (idx_inc) begin
						idx_q <= idx_q + fce_pkg::STEP_W'(1);
					end
					if (adv) begin
						cur_q   <= (state_q == S_ALLOC) ? cur_q + LW'(1) : x;
						first_q <= 1'b0;
						pend_q  <= 1'b1;
					end
					if (fin) begin
						res_q   <= fin_res;
						st_q    <= fin_st;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	fce_ram #(
		.WIDTH (LW),
		.DEPTH (DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

/* rtl/fat_cluster_chain_engine.sv */
// A write goes from acceptance straight to S_DONE; a read passes through
// S_READ first. Allocate scans one table entry per read; free, walk
// and chain length follow one link per read. The single table read port
// visits one entry per cycle. One request is in work at a time; a finished
// result waits in the output register while the next request is taken.
// After reset the table is cleared entry by entry with req.ready low.
module fat_cluster_chain_engine #(
	parameter int unsigned TABLE_DEPTH = fce_pkg::TABLE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	fce_req_if.sink   req,
	fce_rsp_if.source rsp,
	fce_cfg_if.sink   cfg
);

	logic [fce_pkg::CFG_W-1:0] total_q;
	fce_pkg::request_t         eng_req;
	fce_pkg::result_t          eng_res;
	fce_pkg::result_t          out_q;
	logic                      out_valid_q;
	logic                      eng_valid, eng_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= fce_pkg::TOTAL_RESET;
		end else if (cfg.valid) begin
			total_q <= cfg.total_clusters;
		end
	end

	assign eng_req.req_type    = req.req_type;
	assign eng_req.cluster     = req.cluster;
	assign eng_req.entry_value = req.entry_value;
	assign eng_req.link_steps  = req.link_steps;

	fce_engine #(
		.DEPTH (TABLE_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.total     (total_q),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req       (eng_req),
		.res_valid (eng_valid),
		.res_ready (eng_ready),
		.res       (eng_res)
	);

	assign eng_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_ready) begin
			out_valid_q <= eng_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_ready && eng_valid) begin
			out_q <= eng_res;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.result_cluster = out_q.result_cluster;
	assign rsp.chain_count    = out_q.chain_count;
	assign rsp.status         = out_q.status;

endmodule

/* rtl/fce_checker.sv */
`include "fat_cluster_chain_engine_defines.svh"

module fce_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [fce_pkg::LINK_W-1:0] rsp_result_cluster,
	input logic [fce_pkg::CNT_W-1:0]  rsp_chain_count,
	input logic [1:0]                 rsp_status
);

	`FCCE_CHECK(a_rsp_hold, (rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_cluster) && $stable(rsp_chain_count) && $stable(rsp_status)), "response changed while stalled")
	`FCCE_CHECK(a_err_zero, (rsp_valid && rsp_status != fce_pkg::ST_OK |-> rsp_result_cluster == '0), "error response with nonzero cluster")
	`FCCE_CHECK(a_cnt_excl, (rsp_valid && rsp_result_cluster != '0 |-> rsp_chain_count == '0), "cluster and count both nonzero")
	`FCCE_CHECK(a_one_busy, (req_valid && req_ready |=> !req_ready), "second request taken while busy")

endmodule

bind fat_cluster_chain_engine fce_checker u_fce_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_result_cluster (rsp.result_cluster),
	.rsp_chain_count    (rsp.chain_count),
	.rsp_status         (rsp.status)
);
